>>> design/video_codec_level_select_core_defines.svh
// assertion macros for the level select core
`ifndef VIDEO_CODEC_LEVEL_SELECT_CORE_DEFINES_SVH
`define VIDEO_CODEC_LEVEL_SELECT_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define VCLS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define VCLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VCLS_ASSERT_IMPL(label, ante, cons)
`define VCLS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> design/vcls_pkg.sv
package vcls_pkg;

    localparam int AVC_LEVELS  = 15;
    localparam int HEVC_LEVELS = 13;

    localparam logic [1:0] CODEC_SELECT_ADDR = 2'd0;

    localparam logic [5:0] AVC_TOP_CODE  = 6'd52;
    localparam logic [5:0] HEVC_TOP_CODE = 6'd62;

    localparam logic [5:0] AVC_CODE [AVC_LEVELS] = '{
        6'd10, 6'd11, 6'd12, 6'd13, 6'd20, 6'd21, 6'd22, 6'd30,
        6'd31, 6'd32, 6'd41, 6'd42, 6'd50, 6'd51, 6'd52
    };
    localparam logic [31:0] AVC_SAMPLES [AVC_LEVELS] = '{
        32'd25344, 32'd101376, 32'd101376, 32'd101376, 32'd101376,
        32'd202752, 32'd414720, 32'd414720, 32'd921600, 32'd1310720,
        32'd2097152, 32'd2228224, 32'd5652480, 32'd9437184, 32'd9437184
    };
    localparam logic [31:0] AVC_RATE [AVC_LEVELS] = '{
        32'd380160, 32'd768000, 32'd1536000, 32'd3041280, 32'd3041280,
        32'd5068800, 32'd5184000, 32'd10368000, 32'd27648000, 32'd55296000,
        32'd62914560, 32'd133693440, 32'd150994944, 32'd251658240, 32'd530841600
    };

    localparam logic [5:0] HEVC_CODE [HEVC_LEVELS] = '{
        6'd10, 6'd20, 6'd21, 6'd30, 6'd31, 6'd40, 6'd41,
        6'd50, 6'd51, 6'd52, 6'd60, 6'd61, 6'd62
    };
    localparam logic [31:0] HEVC_SAMPLES [HEVC_LEVELS] = '{
        32'd36864, 32'd122880, 32'd245760, 32'd552960, 32'd983040,
        32'd2228224, 32'd2228224, 32'd8912896, 32'd8912896, 32'd8912896,
        32'd35651584, 32'd35651584, 32'd35651584
    };
    localparam logic [31:0] HEVC_RATE [HEVC_LEVELS] = '{
        32'd552960, 32'd3686400, 32'd7372800, 32'd16588800, 32'd33177600,
        32'd66846720, 32'd133693440, 32'd267386880, 32'd534773760,
        32'd1069547520, 32'd1069547520, 32'd2139095040, 32'd4278190080
    };

    typedef struct packed {
        logic        valid;
        logic        sat;
        logic [31:0] rem;
        logic [31:0] word;
        logic [31:0] den;
        logic [31:0] samples;
    } div_stage_t;

    typedef struct packed {
        logic [5:0] code;
        logic       exceeds;
    } level_result_t;

    // rate is quo rounded up by round_up, saturated when sat
    function automatic logic level_fits(
        logic [31:0] samples, logic [31:0] quo, logic round_up, logic sat,
        logic [31:0] max_samples, logic [31:0] max_rate
    );
        logic rate_ok;
        rate_ok = round_up ? (quo < max_rate) : (quo <= max_rate);
        return (samples <= max_samples) && !sat && rate_ok;
    endfunction

    function automatic level_result_t pick_level(
        logic hevc, logic [31:0] samples, logic [31:0] quo, logic round_up, logic sat
    );
        level_result_t res;
        res.code    = hevc ? HEVC_TOP_CODE : AVC_TOP_CODE;
        res.exceeds = 1'b1;
        if (hevc)
        begin
            for (int i = HEVC_LEVELS - 1; i >= 0; i--)
            begin
                if (level_fits(samples, quo, round_up, sat, HEVC_SAMPLES[i], HEVC_RATE[i]))
                begin
                    res.code    = HEVC_CODE[i];
                    res.exceeds = 1'b0;
                end
            end
        end
        else
        begin
            for (int i = AVC_LEVELS - 1; i >= 0; i--)
            begin
                if (level_fits(samples, quo, round_up, sat, AVC_SAMPLES[i], AVC_RATE[i]))
                begin
                    res.code    = AVC_CODE[i];
                    res.exceeds = 1'b0;
                end
            end
        end
        return res;
    endfunction

endpackage

>>> design/vcls_front.sv
module vcls_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                load,
    input  logic [15:0]         frame_width,
    input  logic [15:0]         frame_height,
    input  logic [31:0]         rate_numerator,
    input  logic [31:0]         rate_denominator,
    output vcls_pkg::div_stage_t stage_out
);

    logic        s1_valid_reg;
    logic        s2_valid_reg;
    logic        s3_valid_reg;
    logic [31:0] s1_samples_reg;
    logic [31:0] s1_num_reg;
    logic [31:0] s1_den_reg;
    logic [63:0] s2_prod_reg;
    logic [31:0] s2_samples_reg;
    logic [31:0] s2_den_reg;
    logic        s3_sat_reg;
    logic [31:0] s3_rem_reg;
    logic [31:0] s3_word_reg;
    logic [31:0] s3_den_reg;
    logic [31:0] s3_samples_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= load;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // picture size, then full 64-bit product, then overflow check
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_samples_reg <= 32'(frame_width) * 32'(frame_height);
            s1_num_reg     <= rate_numerator;
            s1_den_reg     <= rate_denominator;
            s2_prod_reg    <= 64'(s1_samples_reg) * 64'(s1_num_reg);
            s2_samples_reg <= s1_samples_reg;
            s2_den_reg     <= s1_den_reg;
            s3_sat_reg     <= (s2_den_reg == 32'd0) || (s2_prod_reg[63:32] >= s2_den_reg);
            s3_rem_reg     <= s2_prod_reg[63:32];
            s3_word_reg    <= s2_prod_reg[31:0];
            s3_den_reg     <= s2_den_reg;
            s3_samples_reg <= s2_samples_reg;
        end
    end

    always_comb
    begin
        stage_out.valid   = s3_valid_reg;
        stage_out.sat     = s3_sat_reg;
        stage_out.rem     = s3_rem_reg;
        stage_out.word    = s3_word_reg;
        stage_out.den     = s3_den_reg;
        stage_out.samples = s3_samples_reg;
    end

endmodule

>>> design/vcls_div_cell.sv
module vcls_div_cell
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  vcls_pkg::div_stage_t stage_in,
    output vcls_pkg::div_stage_t stage_out
);

    logic        valid_reg;
    logic        sat_reg;
    logic [31:0] rem_reg;
    logic [31:0] word_reg;
    logic [31:0] den_reg;
    logic [31:0] samples_reg;
    logic [32:0] trial;
    logic [31:0] diff;
    logic        fits;
    logic [31:0] rem_next;
    logic [31:0] word_next;

    // one restoring division step, quotient bit shifts into the low word
    always_comb
    begin
        trial     = {stage_in.rem, stage_in.word[31]};
        diff      = trial[31:0] - stage_in.den;
        fits      = trial >= {1'b0, stage_in.den};
        rem_next  = fits ? diff : trial[31:0];
        word_next = {stage_in.word[30:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg     <= stage_in.sat;
            rem_reg     <= rem_next;
            word_reg    <= word_next;
            den_reg     <= stage_in.den;
            samples_reg <= stage_in.samples;
        end
    end

    always_comb
    begin
        stage_out.valid   = valid_reg;
        stage_out.sat     = sat_reg;
        stage_out.rem     = rem_reg;
        stage_out.word    = word_reg;
        stage_out.den     = den_reg;
        stage_out.samples = samples_reg;
    end

endmodule

>>> design/video_codec_level_select_core.sv
// path: an input transfer goes through the front stages, the division cells and the output register to the result
// throughput: one item per cycle while in_stall is low, through a chain of 32 division cells, one quotient bit each
// a 2-entry output stage (register plus skid) absorbs output stalls
// reset: asynchronous active low, clears all valid bits and codec_select to avc
`include "video_codec_level_select_core_defines.svh"

module video_codec_level_select_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] frame_width,
    input  logic [15:0] frame_height,
    input  logic [31:0] rate_numerator,
    input  logic [31:0] rate_denominator,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  level_code,
    output logic        exceeds_all,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DIV_CELLS = 32;

    vcls_pkg::div_stage_t    chain [DIV_CELLS + 1];
    vcls_pkg::level_result_t pick;

    logic       codec_select_reg;
    logic       en;
    logic       load;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       skid_valid_reg;
    logic       skid_valid_next;
    logic [5:0] out_level_reg;
    logic [5:0] out_level_next;
    logic       out_exceeds_reg;
    logic       out_exceeds_next;
    logic [5:0] skid_level_reg;
    logic [5:0] skid_level_next;
    logic       skid_exceeds_reg;
    logic       skid_exceeds_next;

    assign pready = 1'b1;
    assign prdata = (paddr == vcls_pkg::CODEC_SELECT_ADDR) ? {31'd0, codec_select_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_select_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr == vcls_pkg::CODEC_SELECT_ADDR))
        begin
            codec_select_reg <= pwdata[0];
        end
    end

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign load     = in_valid && !in_stall;

    vcls_front u_front
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .load             (load),
        .frame_width      (frame_width),
        .frame_height     (frame_height),
        .rate_numerator   (rate_numerator),
        .rate_denominator (rate_denominator),
        .stage_out        (chain[0])
    );

    for (genvar g = 0; g < DIV_CELLS; g++)
    begin : g_cell
        vcls_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .stage_in  (chain[g]),
            .stage_out (chain[g + 1])
        );
    end

    assign pick = vcls_pkg::pick_level(codec_select_reg, chain[DIV_CELLS].samples,
                                       chain[DIV_CELLS].word, chain[DIV_CELLS].rem != 32'd0,
                                       chain[DIV_CELLS].sat);

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        out_level_next    = out_level_reg;
        out_exceeds_next  = out_exceeds_reg;
        skid_valid_next   = skid_valid_reg;
        skid_level_next   = skid_level_reg;
        skid_exceeds_next = skid_exceeds_reg;
        if (out_valid_reg && out_stall)
        begin
            if (en && chain[DIV_CELLS].valid)
            begin
                skid_valid_next   = 1'b1;
                skid_level_next   = pick.code;
                skid_exceeds_next = pick.exceeds;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_next   = 1'b1;
            out_level_next   = skid_level_reg;
            out_exceeds_next = skid_exceeds_reg;
            skid_valid_next  = 1'b0;
        end
        else
        begin
            out_valid_next   = chain[DIV_CELLS].valid;
            out_level_next   = pick.code;
            out_exceeds_next = pick.exceeds;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_level_reg    <= out_level_next;
        out_exceeds_reg  <= out_exceeds_next;
        skid_level_reg   <= skid_level_next;
        skid_exceeds_reg <= skid_exceeds_next;
    end

    assign out_valid   = out_valid_reg;
    assign level_code  = out_level_reg;
    assign exceeds_all = out_exceeds_reg;

    `VCLS_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `VCLS_ASSERT_NEXT(a_skid_fill_on_stall, !skid_valid_reg && !(out_valid_reg && out_stall), !skid_valid_reg)
    `VCLS_ASSERT_IMPL(a_exceeds_top, out_valid_reg && exceeds_all, level_code == vcls_pkg::AVC_TOP_CODE || level_code == vcls_pkg::HEVC_TOP_CODE)

endmodule
